### rtl/core/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types, sizes and codes for the path normaliser.
// ----------------------------------------------------------------------------
package pns_pkg;

  localparam int NAME_DEPTH = 512;
  localparam int MAX_COMP   = 256;
  localparam int NAME_AW    = $clog2(NAME_DEPTH);
  localparam int PTR_W      = NAME_AW + 1;
  localparam int COMP_AW    = $clog2(MAX_COMP);

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] SEP_RESET = CH_SLASH;

  typedef enum logic [1:0] {
    DOT_NONE  = 2'd0,
    DOT_ONE   = 2'd1,
    DOT_TWO   = 2'd2,
    DOT_OTHER = 2'd3
  } dot_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] ch;
    logic       leading_root;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic latch_feed;
    logic clear;
    logic feed_exec;
    logic loc_issue;
    logic loc_eval;
    logic second;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic yield;
    logic none;
  } dp_status_t;

endpackage

### rtl/core/path_normalizer_stack.sv
// ----------------------------------------------------------------------------
// path_normalizer_stack
// Streaming path normaliser with dot-segment removal and character read-out.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A feed command
// raises busy for its update step: the start stack is read in
// the accepting cycle, then pointers and the stores are updated. Clear
// completes at its accepting edge and never raises busy. A read command runs
// a read/evaluate loop over the registered name store and start stack ports,
// a read and an evaluate state per pass: one pass when nothing remains, two
// when a character is found, plus one more pass for every component boundary
// that must be stepped over. Its result is on out_result for the single cycle
// that out_strobe is high, which is the first cycle with busy low again. The
// receiver cannot stall: out_result must be captured while out_strobe is
// high. Only read commands produce a result. The user must write the separator
// register through cfg_we/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module path_normalizer_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pns_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output pns_pkg::out_item_t  out_result,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  pns_pkg::dp_cmd_t    cmd;
  pns_pkg::dp_status_t status;

  pns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_item.command),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  pns_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_result (out_result)
  );

endmodule

### rtl/core/pns_ctrl.sv
// ----------------------------------------------------------------------------
// pns_ctrl
// Sequencer: feed with an update state, read/evaluate loop for read-out, result strobe.
// ----------------------------------------------------------------------------
module pns_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_command,
  input  pns_pkg::dp_status_t  status,
  output pns_pkg::dp_cmd_t     cmd,
  output logic                 busy,
  output logic                 out_strobe
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FEED   = 4'b0010,
    S_LOC_RD = 4'b0100,
    S_LOC_EV = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            pns_pkg::CMD_FEED: begin
              cmd.latch_feed = 1'b1;
              state_nxt      = S_FEED;
            end
            pns_pkg::CMD_READ: begin
              phase_nxt = 1'b0;
              state_nxt = S_LOC_RD;
            end
            pns_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_FEED: begin
        cmd.feed_exec = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_LOC_RD: begin
        cmd.loc_issue = 1'b1;
        state_nxt     = S_LOC_EV;
      end
      S_LOC_EV: begin
        cmd.loc_eval = 1'b1;
        cmd.second   = phase_r;
        // first pass finds the character, second pass only decides last
        if (status.none || (status.yield && phase_r)) begin
          cmd.emit   = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          if (status.yield) begin
            phase_nxt = 1'b1;
          end
          state_nxt = S_LOC_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

### rtl/core/pns_datapath.sv
// ----------------------------------------------------------------------------
// pns_datapath
// Name store, component start stack, write/read pointers and result register.
// ----------------------------------------------------------------------------
module pns_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  pns_pkg::in_item_t    in_item,
  input  pns_pkg::dp_cmd_t     cmd,
  output pns_pkg::dp_status_t  status,
  output pns_pkg::out_item_t   out_result
);

  localparam int PW = pns_pkg::PTR_W;
  localparam int CW = pns_pkg::COMP_AW;
  localparam int AW = pns_pkg::NAME_AW;

  logic [7:0]    name_mem   [pns_pkg::NAME_DEPTH];
  logic [PW-1:0] starts_mem [pns_pkg::MAX_COMP];

  logic [7:0]    sep_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic          at_start_r, at_start_nxt;
  logic          open_r, open_nxt;
  pns_pkg::dot_t dot_r, dot_nxt;
  logic          root_shifted_r, root_shifted_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          rs_r, rs_nxt;
  logic          ovf_r, ovf_nxt;

  logic [7:0]    ch_r;
  logic          root_r;
  logic [7:0]    char_r;
  pns_pkg::out_item_t out_r;

  logic [PW-1:0] start_q_r;
  logic          start_zero_r;
  logic [7:0]    name_q_r;
  logic [PW-1:0] start_val;

  logic [CW-1:0] st_ra, feed_ra, st_wa;
  logic [PW-1:0] st_wd;
  logic          st_we;
  logic [AW-1:0] nm_wa;
  logic [7:0]    nm_wd;
  logic          nm_we;

  logic [CW-1:0] count_inc;
  logic [CW:0]   rc_inc;
  logic [PW-1:0] wp_inc;
  logic          wp_room, count_room;
  logic          is_sep, is_nul, fresh, do_append;

  logic          loc_yield, loc_none, loc_more;
  logic [7:0]    loc_char;

  assign count_inc  = count_r + CW'(1);
  assign rc_inc     = {1'b0, rc_r} + (CW+1)'(1);
  assign wp_inc     = wp_r + PW'(1);
  assign wp_room    = (wp_r < PW'(pns_pkg::NAME_DEPTH));
  assign count_room = (count_r < CW'(pns_pkg::MAX_COMP - 1));
  assign is_sep     = (ch_r == pns_pkg::CH_SLASH) || (ch_r == pns_pkg::CH_BSLASH);
  assign is_nul     = (ch_r == pns_pkg::CH_NUL);
  assign fresh      = at_start_r || !open_r;

  // closing ".." reads the start of the component below; otherwise the current one
  assign feed_ra = ((dot_r == pns_pkg::DOT_TWO) && (count_r != '0)) ?
                   count_r - CW'(1) : count_r;
  assign st_ra   = cmd.loc_issue ? rc_inc[CW-1:0] : feed_ra;

  // entry zero of the stack is always 0 and never written
  assign start_val = start_zero_r ? '0 : start_q_r;

  always_ff @(posedge clk) begin
    start_q_r    <= starts_mem[st_ra];
    start_zero_r <= (st_ra == '0);
    name_q_r     <= name_mem[rp_r[AW-1:0]];
    if (st_we) begin
      starts_mem[st_wa] <= st_wd;
    end
    if (nm_we) begin
      name_mem[nm_wa] <= nm_wd;
    end
  end

  // read-out position evaluation, one step per pass
  always_comb begin
    loc_yield = 1'b0;
    loc_none  = 1'b0;
    loc_char  = sep_r;
    loc_more  = (rc_inc < {1'b0, count_r}) && !(root_shifted_r && (rc_r == '0));
    if (rc_r >= count_r) begin
      loc_none = 1'b1;
    end else if (rs_r) begin
      loc_yield = 1'b1;
    end else if (rp_r < start_val) begin
      loc_yield = 1'b1;
      loc_char  = name_q_r;
    end
  end

  assign status.yield = loc_yield;
  assign status.none  = loc_none;

  always_comb begin
    count_nxt        = count_r;
    wp_nxt           = wp_r;
    at_start_nxt     = at_start_r;
    open_nxt         = open_r;
    dot_nxt          = dot_r;
    root_shifted_nxt = root_shifted_r;
    rc_nxt           = rc_r;
    rp_nxt           = rp_r;
    rs_nxt           = rs_r;
    ovf_nxt          = ovf_r;
    nm_we            = 1'b0;
    nm_wa            = wp_r[AW-1:0];
    nm_wd            = ch_r;
    st_we            = 1'b0;
    st_wa            = count_inc;
    st_wd            = wp_r;
    do_append        = 1'b0;
    if (cmd.clear) begin
      count_nxt        = '0;
      wp_nxt           = '0;
      at_start_nxt     = 1'b1;
      open_nxt         = 1'b0;
      dot_nxt          = pns_pkg::DOT_NONE;
      root_shifted_nxt = 1'b0;
      rc_nxt           = '0;
      rp_nxt           = '0;
      rs_nxt           = 1'b0;
      ovf_nxt          = 1'b0;
    end else if (cmd.latch_feed) begin
      rc_nxt = '0;
      rp_nxt = '0;
      rs_nxt = 1'b0;
    end else if (cmd.feed_exec) begin
      if (at_start_r) begin
        if (is_sep || is_nul) begin
          if (root_r) begin
            if (wp_room && count_room) begin
              nm_we            = 1'b1;
              nm_wd            = sep_r;
              wp_nxt           = wp_inc;
              count_nxt        = count_inc;
              st_we            = 1'b1;
              st_wd            = wp_inc;
              root_shifted_nxt = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (!is_nul) begin
            at_start_nxt = 1'b0;
            open_nxt     = 1'b0;
          end
        end else begin
          at_start_nxt = 1'b0;
          do_append    = 1'b1;
        end
      end else if (!open_r) begin
        if (is_nul) begin
          at_start_nxt = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end else if (is_sep || is_nul) begin
        case (dot_r)
          pns_pkg::DOT_ONE: wp_nxt = start_val;
          pns_pkg::DOT_TWO: begin
            if (count_r != '0) begin
              count_nxt = count_r - CW'(1);
            end
            wp_nxt = start_val;
          end
          default: begin
            if (count_room) begin
              count_nxt = count_inc;
              st_we     = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
              wp_nxt  = start_val;
            end
          end
        endcase
        open_nxt = 1'b0;
        dot_nxt  = pns_pkg::DOT_NONE;
        if (is_nul) begin
          at_start_nxt = 1'b1;
        end
      end else begin
        do_append = 1'b1;
      end
      if (do_append) begin
        if (fresh) begin
          dot_nxt = (ch_r == pns_pkg::CH_DOT) ? pns_pkg::DOT_ONE : pns_pkg::DOT_OTHER;
        end else if ((dot_r == pns_pkg::DOT_ONE) && (ch_r == pns_pkg::CH_DOT)) begin
          dot_nxt = pns_pkg::DOT_TWO;
        end else begin
          dot_nxt = pns_pkg::DOT_OTHER;
        end
        open_nxt = 1'b1;
        if (wp_room) begin
          nm_we  = 1'b1;
          wp_nxt = wp_inc;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end else if (cmd.loc_eval) begin
      if (!loc_none && !loc_yield) begin
        if (loc_more) begin
          rs_nxt = 1'b1;
        end else begin
          rc_nxt = rc_inc[CW-1:0];
          rp_nxt = start_val;
        end
      end else if (loc_yield && !cmd.second) begin
        if (rs_r) begin
          rs_nxt = 1'b0;
          rc_nxt = rc_inc[CW-1:0];
          rp_nxt = start_val;
        end else begin
          rp_nxt = rp_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r          <= pns_pkg::SEP_RESET;
      count_r        <= '0;
      wp_r           <= '0;
      at_start_r     <= 1'b1;
      open_r         <= 1'b0;
      dot_r          <= pns_pkg::DOT_NONE;
      root_shifted_r <= 1'b0;
      rc_r           <= '0;
      rp_r           <= '0;
      rs_r           <= 1'b0;
      ovf_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
      count_r        <= count_nxt;
      wp_r           <= wp_nxt;
      at_start_r     <= at_start_nxt;
      open_r         <= open_nxt;
      dot_r          <= dot_nxt;
      root_shifted_r <= root_shifted_nxt;
      rc_r           <= rc_nxt;
      rp_r           <= rp_nxt;
      rs_r           <= rs_nxt;
      ovf_r          <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_feed) begin
      ch_r   <= in_item.ch;
      root_r <= in_item.leading_root;
    end
    if (cmd.loc_eval && loc_yield && !cmd.second) begin
      char_r <= loc_char;
    end
    if (cmd.emit) begin
      out_r.out_char  <= cmd.second ? char_r : 8'd0;
      out_r.out_valid <= cmd.second;
      out_r.out_last  <= loc_none;
      out_r.overflow  <= ovf_r;
    end
  end

  assign out_result = out_r;

endmodule

### rtl/core/pns_checker.sv
// ----------------------------------------------------------------------------
// pns_checker
// Port-level checks on the path normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module pns_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pns_pkg::in_item_t   in_item,
  input logic                out_strobe,
  input pns_pkg::out_item_t  out_result
);

  // a read always passes through its read and evaluate states before its result
  a_no_adjacent_results: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$past(out_strobe))
  else $error("results on consecutive cycles");

  a_result_after_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
  else $error("result without a preceding busy period");

  a_empty_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.out_valid) |->
      (out_result.out_last && (out_result.out_char == 8'd0)))
  else $error("empty result not marked last or char non-zero");

  a_feed_goes_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.command == pns_pkg::CMD_FEED)) |=> (busy && !out_strobe))
  else $error("feed transaction did not hold busy");

endmodule

bind path_normalizer_stack pns_checker u_pns_checker (.*);

### dv/pns_readout_checker.sv
// ----------------------------------------------------------------------------
// pns_readout_checker
// Watches the command, result and separator ports of the path normaliser,
// keeps its own model of the component stack and name store, and checks
// every read result against the predicted character, flags and overflow.
// ----------------------------------------------------------------------------
module pns_readout_checker
  import pns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_strobe,
  input  out_item_t  out_result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending_count
);

  logic [7:0]  name_mem   [NAME_DEPTH];
  int unsigned comp_start [MAX_COMP];
  int unsigned n_comp;
  int unsigned wr_ptr;
  int unsigned rd_comp;
  int unsigned rd_ptr;
  bit          path_start;
  bit          comp_open;
  bit          root_shift;
  bit          rd_in_sep;
  bit          ovf_seen;
  dot_t        dot_st;
  logic [7:0]  sep_char;
  out_item_t   expected_chars [$];
  out_item_t   want;
  int          mismatches;

  // name_mem is left alone: nothing unwritten is ever read back
  function automatic void clear_norm();
    foreach (comp_start[i]) comp_start[i] = 0;
    n_comp     = 0;
    wr_ptr     = 0;
    path_start = 1'b1;
    comp_open  = 1'b0;
    dot_st     = DOT_NONE;
    root_shift = 1'b0;
    rd_comp    = 0;
    rd_ptr     = 0;
    rd_in_sep  = 1'b0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void append_char(logic [7:0] c);
    if (!comp_open) begin
      dot_st = (c == CH_DOT) ? DOT_ONE : DOT_OTHER;
    end else if (dot_st == DOT_ONE && c == CH_DOT) begin
      dot_st = DOT_TWO;
    end else begin
      dot_st = DOT_OTHER;
    end
    comp_open = 1'b1;
    if (wr_ptr < NAME_DEPTH) begin
      name_mem[wr_ptr] = c;
      wr_ptr++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void close_comp();
    case (dot_st)
      DOT_ONE: wr_ptr = comp_start[n_comp];
      DOT_TWO: begin
        // nothing to pop at depth zero, the component just vanishes
        if (n_comp > 0) n_comp--;
        wr_ptr = comp_start[n_comp];
      end
      default: begin
        if (n_comp + 1 < MAX_COMP) begin
          n_comp++;
          comp_start[n_comp] = wr_ptr;
        end else begin
          ovf_seen = 1'b1;
          wr_ptr   = comp_start[n_comp];
        end
      end
    endcase
    comp_open = 1'b0;
    dot_st    = DOT_NONE;
  endfunction

  function automatic void push_root();
    if (wr_ptr < NAME_DEPTH && n_comp + 1 < MAX_COMP) begin
      name_mem[wr_ptr] = sep_char;
      wr_ptr++;
      n_comp++;
      comp_start[n_comp] = wr_ptr;
      root_shift = 1'b1;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void feed_char(logic [7:0] c, logic root);
    bit is_sep;
    is_sep    = (c == CH_SLASH || c == CH_BSLASH);
    rd_comp   = 0;
    rd_ptr    = comp_start[0];
    rd_in_sep = 1'b0;
    if (path_start) begin
      if (is_sep || c == CH_NUL) begin
        if (root) push_root();
        if (c != CH_NUL) begin
          path_start = 1'b0;
          comp_open  = 1'b0;
        end
      end else begin
        path_start = 1'b0;
        comp_open  = 1'b0;
        append_char(c);
      end
    end else if (!comp_open) begin
      // first character of a component goes in as is, separator or not
      if (c == CH_NUL) path_start = 1'b1;
      else append_char(c);
    end else if (is_sep || c == CH_NUL) begin
      close_comp();
      if (c == CH_NUL) path_start = 1'b1;
    end else begin
      append_char(c);
    end
  endfunction

  // Walks forward to the next position that yields a character
  function automatic bit next_char(inout int unsigned c, inout int unsigned p, inout bit s,
                                   output logic [7:0] chr);
    chr = CH_NUL;
    while (c < n_comp) begin
      if (s) begin
        chr = sep_char;
        return 1'b1;
      end
      if (p < comp_start[c + 1] && p < NAME_DEPTH) begin
        chr = name_mem[p];
        return 1'b1;
      end
      // no joining separator straight after a root component
      if (c + 1 < n_comp && !(root_shift && c == 0)) begin
        s = 1'b1;
      end else begin
        c++;
        p = comp_start[c];
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_read();
    int unsigned c;
    int unsigned p;
    bit          s;
    bit          hit;
    bit          more;
    logic [7:0]  chr;
    logic [7:0]  peek;
    out_item_t   r;
    c    = rd_comp;
    p    = rd_ptr;
    s    = rd_in_sep;
    more = 1'b0;
    hit  = next_char(c, p, s, chr);
    if (hit) begin
      if (s) begin
        s = 1'b0;
        c++;
        p = comp_start[c];
      end else begin
        p++;
      end
      more      = next_char(c, p, s, peek);
      rd_comp   = c;
      rd_ptr    = p;
      rd_in_sep = s;
    end else begin
      chr = CH_NUL;
    end
    r.out_char  = chr;
    r.out_valid = hit;
    r.out_last  = !more;
    r.overflow  = ovf_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sep_char = SEP_RESET;
      clear_norm();
      expected_chars.delete();
      mismatches = 0;
    end else begin
      // results belong to earlier reads, so check before taking a new transaction
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: char %h valid %b last %b ovf %b",
                     out_result.out_char, out_result.out_valid,
                     out_result.out_last, out_result.overflow);
        end else begin
          want = expected_chars.pop_front();
          if (out_result.out_char  !== want.out_char  ||
              out_result.out_valid !== want.out_valid ||
              out_result.out_last  !== want.out_last  ||
              out_result.overflow  !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("read mismatch: exp char %h valid %b last %b ovf %b, ",
                       want.out_char, want.out_valid, want.out_last, want.overflow,
                       "got char %h valid %b last %b ovf %b",
                       out_result.out_char, out_result.out_valid,
                       out_result.out_last, out_result.overflow);
          end
        end
      end
      if (cfg_we) sep_char = cfg_wdata;
      if (start && !busy) begin
        case (in_item.command)
          CMD_FEED:  feed_char(in_item.ch, in_item.leading_root);
          CMD_READ:  expected_chars.push_back(predict_read());
          CMD_CLEAR: clear_norm();
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_chars.size();
  end

endmodule

### dv/tb_path_normalizer_stack.sv
// ----------------------------------------------------------------------------
// tb_path_normalizer_stack
// Drives the path normaliser with directed paths (dot segments, roots,
// separators as first characters, popping back through a root) and then
// random path sequences with read-out bursts, noise and separator changes,
// under several sender idling patterns. Checking is done by
// pns_readout_checker.
// ----------------------------------------------------------------------------
module tb_path_normalizer_stack;
  import pns_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 500;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       out_strobe;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  in_item_t   in_item;
  out_item_t  out_result;

  int n_fail;
  int n_pending;
  int stall_cycles;
  int idle_pct;
  int items_sent;
  int fed_since_clear;
  int idle_plan [4] = '{0, 56, 0, 27};

  path_normalizer_stack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pns_readout_checker u_readout_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_result    (out_result),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (n_fail),
    .pending_count (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with neither a transaction taken nor a result seen
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [7:0] c, input logic root);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item <= '{command: cmd, ch: c, leading_root: root};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_FEED) fed_since_clear++;
    if (cmd == CMD_CLEAR) fed_since_clear = 0;
  endtask

  task automatic feed_path(input string s, input logic root, input bit term);
    for (int i = 0; i < s.len(); i++) send(CMD_FEED, s[i], root);
    if (term) send(CMD_FEED, CH_NUL, root);
  endtask

  task automatic read_burst(input int n);
    repeat (n) send(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // let the last transaction drain; feeds give no result, hence the extra cycles
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_sep(input logic [7:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sep();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 5))
      0:       return CH_DOT;
      1:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  task automatic random_path();
    logic root;
    int   n_parts;
    int   kind;
    root = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 2) != 0) send(CMD_FEED, pick_sep(), root);
    n_parts = $urandom_range(1, 4);
    for (int i = 0; i < n_parts; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send(CMD_FEED, CH_DOT, root);
      end else if (kind < 4) begin
        send(CMD_FEED, CH_DOT, root);
        send(CMD_FEED, CH_DOT, root);
      end else begin
        // a doubled separator makes the second one the component's first char
        if (kind == 4) send(CMD_FEED, pick_sep(), root);
        repeat ($urandom_range(1, 3)) send(CMD_FEED, pick_name_char(), root);
      end
      if (i + 1 < n_parts || $urandom_range(0, 3) == 0) send(CMD_FEED, pick_sep(), root);
    end
    if ($urandom_range(0, 9) != 0) send(CMD_FEED, CH_NUL, root);
  endtask

  initial begin
    int n_reads;
    int phase;
    int last_phase;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    idle_pct        = 0;
    items_sent      = 0;
    fed_since_clear = 0;
    last_phase      = -1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset separator
    read_burst(1);
    feed_path("/a/./b/../cd", 1'b1, 1'b1);
    read_burst(6);
    feed_path("..//x\\", 1'b0, 1'b1);
    read_burst(7);
    send(CMD_CLEAR, 8'hFF, 1'b1);
    feed_path("../.", 1'b0, 1'b1);
    send(CMD_FEED, 8'hFF, 1'b1);
    send(CMD_FEED, CH_NUL, 1'b1);
    send(CMD_FEED, CH_NUL, 1'b1);
    send(CMD_UNUSED, 8'hAA, 1'b1);
    read_burst(4);

    // a run of components under a root, then dot-dots back through it
    send(CMD_CLEAR, 8'h00, 1'b0);
    send(CMD_FEED, CH_SLASH, 1'b1);
    repeat (6) feed_path("abc/", 1'b0, 1'b0);
    read_burst(12);
    send(CMD_FEED, CH_NUL, 1'b0);
    send(CMD_FEED, CH_BSLASH, 1'b1);
    feed_path("../..", 1'b0, 1'b1);
    read_burst(4);
    send(CMD_CLEAR, 8'h00, 1'b0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase = items_sent * 4 / RANDOM_ITEMS;
      if (phase != last_phase) begin
        case (phase)
          0:       write_sep(8'hFF);
          1:       write_sep(8'h00);
          2:       write_sep(CH_BSLASH);
          default: write_sep(SEP_RESET);
        endcase
        idle_pct   = idle_plan[phase];
        last_phase = phase;
      end else if ($urandom_range(0, 11) == 0) begin
        write_sep(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) != 0) begin
        if (fed_since_clear > 40 || $urandom_range(0, 4) == 0)
          send(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 2)) random_path();
        n_reads = $urandom_range(0, 1) ? fed_since_clear + 3
                                       : $urandom_range(1, fed_since_clear + 3);
        read_burst(n_reads);
      end else begin
        repeat ($urandom_range(1, 6))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (n_pending != 0) $display("%0d read results never arrived", n_pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
